FILE: rtl/gpfp_pkg.sv
// shared types, character codes and header table for the position field packer
`timescale 1ns / 1ps

package gpfp_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ABORT = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    // one queue entry: up to two results from a single request
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        t_kind      kind0;
        logic [7:0] byte1;
    } t_entry;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int HIDX_W      = 3;
    localparam int FCNT_W      = 4;

    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [7:0] DIGIT_OFS  = 8'd48;
    localparam logic [7:0] PACK_OFS   = 8'd32;

    localparam logic [FCNT_W-1:0] FIELD_SKIP_HI  = 4'd2;
    localparam logic [FCNT_W-1:0] FIELD_SKIP_MID = 4'd5;

    function automatic logic [7:0] hdr_char(input logic [HIDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;  // $
            3'd1:    c = 8'h50;  // P
            3'd2:    c = 8'h47;  // G
            3'd3:    c = 8'h52;  // R
            3'd4:    c = 8'h4D;  // M
            3'd5:    c = 8'h46;  // F
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/gpfp_if.sv
// valid/ready channel interfaces for sentence bytes and packed results
`timescale 1ns / 1ps

interface gpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       sentence_start;

    modport source (output valid, output rx_byte, output sentence_start, input ready);
    modport sink   (input valid, input rx_byte, input sentence_start, output ready);
endinterface

interface gpfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

FILE: rtl/gps_position_field_packer.sv
// top level of the position sentence field packer
//
// usage:
//   i_in carries one sentence character per request (rx_byte) with
//   sentence_start marking the first byte of a sentence; o_out carries the
//   results (out_byte, kind, last). both channels use valid/ready.
//   the front end checks the header, counts commas and packs digit pairs;
//   each request that yields results pushes one entry (one or two results)
//   into a four-entry queue, and the output stage issues them one per cycle
//   while o_out.ready is high. a result passes through the queue and the
//   output register before it is presented. throughput: one request per
//   cycle while the queue is not full; a W or E that flushes a half byte
//   yields two results from one entry; the queue absorbs these bursts.
//   when the receiver stalls the queue fills and i_in.ready drops once it
//   holds four entries; requests that produce no result keep flowing until
//   then, and the stalled result holds steady.
//   reset (synchronous, active low) returns to idle, empties the queue and
//   drops any pending output.
`timescale 1ns / 1ps

module gps_position_field_packer #(
    parameter int HEADER_LEN = 6,
    parameter int END_FIELD  = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gpfp_in_if.sink    i_in,
    gpfp_out_if.source o_out
);
    import gpfp_pkg::*;

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_entry push_data;
    t_entry q_data;

    gpfp_front #(
        .HEADER_LEN (HEADER_LEN),
        .END_FIELD  (END_FIELD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_data)
    );

    gpfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    gpfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/gpfp_front.sv
// front end: header check, field counting and digit packing per received byte
`timescale 1ns / 1ps

module gpfp_front #(
    parameter int HEADER_LEN = 6,
    parameter int END_FIELD  = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gpfp_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output gpfp_pkg::t_entry o_entry
);
    import gpfp_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [HIDX_W:0]   HLEN = (HIDX_W+1)'(HEADER_LEN);
    localparam logic [FCNT_W-1:0] EFLD = FCNT_W'(END_FIELD);

    logic [1:0]        r_phase, n_phase;
    logic [HIDX_W-1:0] r_hidx, n_hidx;
    logic [FCNT_W-1:0] r_fc, n_fc;
    logic              r_np, n_np;
    logic [7:0]        r_pb, n_pb;

    logic              accept;
    logic [7:0]        c;
    logic [7:0]        d;
    logic [1:0]        ph;
    logic [FCNT_W-1:0] fc_inc;
    logic              push;
    t_entry            ent;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.rx_byte;
    assign d          = 8'(c - DIGIT_OFS);
    assign ph         = i_in.sentence_start ? PH_HEADER : r_phase;
    assign fc_inc     = FCNT_W'(r_fc + 1'b1);

    always_comb begin
        n_phase = r_phase;
        n_hidx  = r_hidx;
        n_fc    = r_fc;
        n_np    = r_np;
        n_pb    = r_pb;
        push    = 1'b0;
        ent     = '{two: 1'b0, byte0: 8'd0, kind0: KIND_DATA, byte1: 8'd0};
        if (i_in.sentence_start) begin
            n_hidx = '0;
            n_fc   = '0;
            n_np   = 1'b0;
            n_pb   = '0;
        end
        case (ph)
            PH_HEADER: begin
                if (c != hdr_char(i_in.sentence_start ? '0 : r_hidx)) begin
                    push      = 1'b1;
                    ent.kind0 = KIND_ABORT;
                    n_phase   = PH_IDLE;
                    n_hidx    = '0;
                end else if ((HIDX_W+1)'(n_hidx) + 1'b1 >= HLEN) begin
                    n_phase = PH_BODY;
                    n_hidx  = '0;
                end else begin
                    n_phase = PH_HEADER;
                    n_hidx  = HIDX_W'(n_hidx + 1'b1);
                end
            end
            PH_BODY: begin
                if (c == CH_COMMA) begin
                    n_fc = fc_inc;
                    if (fc_inc >= EFLD) begin
                        push      = 1'b1;
                        ent.kind0 = KIND_DONE;
                        n_phase   = PH_IDLE;
                        n_fc      = '0;
                        n_np      = 1'b0;
                        n_pb      = '0;
                    end
                end else if (r_fc <= FIELD_SKIP_HI || r_fc == FIELD_SKIP_MID
                             || c == CH_DOT) begin
                    // unstored field or dropped dot
                end else if (c == CH_W || c == CH_E) begin
                    push = 1'b1;
                    if (r_np) begin
                        ent.two   = 1'b1;
                        ent.byte0 = 8'(r_pb + PACK_OFS);
                        ent.byte1 = c;
                        n_np      = 1'b0;
                    end else begin
                        ent.byte0 = c;
                    end
                end else if (c == CH_N || c == CH_S) begin
                    push      = 1'b1;
                    ent.byte0 = c;
                end else if (!r_np) begin
                    n_pb = {d[3:0], 4'd0};
                    n_np = 1'b1;
                end else begin
                    push      = 1'b1;
                    ent.byte0 = 8'(r_pb + d + PACK_OFS);
                    n_np      = 1'b0;
                end
            end
            default: begin
                // idle: bytes without a start marker are ignored
            end
        endcase
    end

    assign o_push  = accept && push;
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hidx  <= '0;
            r_fc    <= '0;
            r_np    <= 1'b0;
            r_pb    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_fc    <= n_fc;
            r_np    <= n_np;
            r_pb    <= n_pb;
        end
    end

    a_hidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> ((HIDX_W+1)'(r_hidx) < HLEN))
        else $error("header index past header length");

    a_nibble_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_np |-> (r_phase == PH_BODY))
        else $error("pending nibble outside body");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc < EFLD)
        else $error("field count reached end without closing record");

endmodule

FILE: rtl/gpfp_queue.sv
// short fifo of result entries between the front end and the output stage
`timescale 1ns / 1ps

module gpfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gpfp_pkg::t_entry i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output gpfp_pkg::t_entry o_data
);
    import gpfp_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= QPTR_W'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= QPTR_W'(r_rp + 1'b1);
            end
            if (i_push && !pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (pop && !i_push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

FILE: rtl/gpfp_back.sv
// output stage: issues one or two results per queue entry with the last flag
`timescale 1ns / 1ps

module gpfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  gpfp_pkg::t_entry i_q_data,
    output logic             o_pop,
    gpfp_out_if.source       o_out
);
    import gpfp_pkg::*;

    t_entry r_entry;
    logic   r_valid;
    logic   r_sel;
    logic   is_last;
    logic   take;
    logic   load;

    assign is_last = r_sel || !r_entry.two;
    assign take    = r_valid && o_out.ready;
    assign load    = i_q_valid && (!r_valid || (take && is_last));
    assign o_pop   = load;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_sel ? r_entry.byte1 : r_entry.byte0;
    assign o_out.kind     = r_sel ? KIND_DATA : r_entry.kind0;
    assign o_out.last     = is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_entry <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (take) begin
            if (is_last) begin
                r_valid <= 1'b0;
                r_sel   <= 1'b0;
            end else begin
                r_sel   <= 1'b1;
            end
        end
    end

    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_valid && r_entry.two))
        else $error("second result selected without a two-result entry");

endmodule
